FILE: rtl/core/tmhc_pkg.sv
package tmhc_pkg;

	localparam int FRAC_BITS = 14;
	localparam int POS_W     = 22;
	localparam int EXT_W     = 15;
	localparam int EDGE_W    = POS_W + 1;
	localparam int IDX_W     = EDGE_W - FRAC_BITS;
	localparam int OVL_W     = FRAC_BITS + 1;

	localparam logic [7:0] CODE_WALL  = 8'h23;
	localparam logic [7:0] CODE_BRICK = 8'h25;
	localparam logic [7:0] CODE_DOOR  = 8'h64;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic CFG_MAP_COLS = 1'b0;
	localparam logic CFG_MAP_ROWS = 1'b1;

	localparam logic [6:0] MAP_COLS_RST = 7'd42;
	localparam logic [4:0] MAP_ROWS_RST = 5'd13;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} side_t;

	typedef struct packed {
		logic tl;
		logic tr;
		logic bl;
		logic br;
	} corner_t;

endpackage

FILE: rtl/core/tile_map_hitbox_collision.sv
// channel | handshake            | payload
// --------+----------------------+--------------------------------------------------
// cfg     | cfg_we               | cfg_idx, cfg_wdata
// in      | in_valid / in_ready  | req_type, tile_row, tile_col, tile_code,
//         |                      | pos_x, pos_y, hitbox_w, hitbox_h
// out     | out_valid / out_ready| hit_top, hit_bottom, hit_left, hit_right
//
// One item per cycle while out_ready keeps the pipe moving; a query result is registered in s1, s2, s3 and s4.
// Loads write the tile row memory at the s1->s2 step and give no result.
// After reset a clearing pass over all MAP_ROWS rows (one memory row a cycle) holds in_ready low.
// Stages advance independently: bubbles close up behind a stalled result, nothing is lost.
module tile_map_hitbox_collision #(
	parameter int MAP_COLS = 64,
	parameter int MAP_ROWS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic                                 cfg_idx,
	input  logic [6:0]                           cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 req_type,
	input  logic [3:0]                           tile_row,
	input  logic [5:0]                           tile_col,
	input  logic [7:0]                           tile_code,
	input  logic signed [tmhc_pkg::POS_W-1:0]    pos_x,
	input  logic signed [tmhc_pkg::POS_W-1:0]    pos_y,
	input  logic [tmhc_pkg::EXT_W-1:0]           hitbox_w,
	input  logic [tmhc_pkg::EXT_W-1:0]           hitbox_h,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit_top,
	output logic                                 hit_bottom,
	output logic                                 hit_left,
	output logic                                 hit_right
);
	import tmhc_pkg::*;

	localparam int RAW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
	localparam int CAW = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;

	logic [6:0] map_cols_q;
	logic [4:0] map_rows_q;
	logic           clr_busy_q;
	logic [RAW-1:0] clr_row_q;

	logic [MAP_COLS-1:0] mem [MAP_ROWS];

	logic en1, en2, en3, en4;

	// stage 1
	logic                     v_s1, type_s1, wr_ok_s1, solid_s1;
	logic [RAW-1:0]           wrow_s1;
	logic [CAW-1:0]           wcol_s1;
	logic signed [EDGE_W-1:0] top_s1, bot_s1, left_s1, right_s1;
	logic signed [EDGE_W-1:0] l_in, t_in;

	// stage 2
	logic                v_s2;
	side_t               bnd_s2;
	corner_t             ok_s2;
	logic [CAW-1:0]      cl_s2, cr_s2;
	logic [OVL_W-1:0]    dt_s2, dl_s2, db_s2, dr_s2;
	logic [MAP_COLS-1:0] rd_top_s2, rd_bot_s2;
	logic signed [IDX_W-1:0] rt, rb, cl, cr;
	logic rt_ok, rb_ok, cl_ok, cr_ok;
	logic signed [EDGE_W-1:0] row_lim, col_lim;
	side_t bnd_c;

	// stage 3
	logic    v_s3;
	side_t   bnd_s3;
	corner_t cor_s3;
	logic    t_lt_l_s3, t_lt_r_s3, b_lt_l_s3, b_lt_r_s3;
	corner_t cor_c;

	// stage 4
	logic  v_s4;
	side_t res_s4;
	side_t side_c;

	function automatic logic row_in(input logic signed [IDX_W-1:0] idx,
		input logic [4:0] lim);
		logic [IDX_W-2:0] mag;
		mag = idx[IDX_W-2:0];
		return !idx[IDX_W-1] && (32'(mag) < 32'(lim)) && (32'(mag) < 32'(MAP_ROWS));
	endfunction

	function automatic logic col_in(input logic signed [IDX_W-1:0] idx,
		input logic [6:0] lim);
		logic [IDX_W-2:0] mag;
		mag = idx[IDX_W-2:0];
		return !idx[IDX_W-1] && (32'(mag) < 32'(lim)) && (32'(mag) < 32'(MAP_COLS));
	endfunction

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1 && !clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q <= MAP_COLS_RST;
			map_rows_q <= MAP_ROWS_RST;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_MAP_COLS) map_cols_q <= cfg_wdata;
			if (cfg_idx == CFG_MAP_ROWS) map_rows_q <= cfg_wdata[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_row_q == RAW'(MAP_ROWS - 1)) clr_busy_q <= 1'b0;
			else clr_row_q <= clr_row_q + RAW'(1);
		end
	end

	// ---- stage 1: edges
	assign l_in = EDGE_W'(pos_x);
	assign t_in = EDGE_W'(pos_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en1) v_s1 <= in_valid && in_ready;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			type_s1  <= req_type;
			wr_ok_s1 <= (32'(tile_row) < 32'(MAP_ROWS)) && (32'(tile_col) < 32'(MAP_COLS));
			solid_s1 <= (tile_code == CODE_WALL) || (tile_code == CODE_BRICK)
				|| (tile_code == CODE_DOOR);
			wrow_s1  <= RAW'(tile_row);
			wcol_s1  <= CAW'(tile_col);
			left_s1  <= l_in;
			top_s1   <= t_in;
			right_s1 <= l_in + $signed(EDGE_W'(hitbox_w));
			bot_s1   <= t_in + $signed(EDGE_W'(hitbox_h));
		end
	end

	// ---- stage 2: bounds, corner indexes, memory access
	assign rt = top_s1[EDGE_W-1:FRAC_BITS];
	assign rb = bot_s1[EDGE_W-1:FRAC_BITS];
	assign cl = left_s1[EDGE_W-1:FRAC_BITS];
	assign cr = right_s1[EDGE_W-1:FRAC_BITS];
	assign rt_ok = row_in(rt, map_rows_q);
	assign rb_ok = row_in(rb, map_rows_q);
	assign cl_ok = col_in(cl, map_cols_q);
	assign cr_ok = col_in(cr, map_cols_q);
	assign row_lim = $signed(EDGE_W'({map_rows_q, {FRAC_BITS{1'b0}}}));
	assign col_lim = $signed(EDGE_W'({map_cols_q, {FRAC_BITS{1'b0}}}));

	always_comb begin
		bnd_c.top    = top_s1[EDGE_W-1];
		bnd_c.bottom = bot_s1 > row_lim;
		bnd_c.left   = left_s1[EDGE_W-1];
		bnd_c.right  = right_s1 > col_lim;
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_row_q] <= '0;
		end else if (en2 && v_s1 && (type_s1 == REQ_LOAD) && wr_ok_s1) begin
			mem[wrow_s1][wcol_s1] <= solid_s1;
		end
		if (en2) begin
			rd_top_s2 <= mem[RAW'(rt[IDX_W-2:0])];
			rd_bot_s2 <= mem[RAW'(rb[IDX_W-2:0])];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en2) v_s2 <= v_s1 && (type_s1 == REQ_QUERY);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			bnd_s2 <= bnd_c;
			ok_s2  <= '{tl: rt_ok && cl_ok, tr: rt_ok && cr_ok,
				bl: rb_ok && cl_ok, br: rb_ok && cr_ok};
			cl_s2  <= CAW'(cl[IDX_W-2:0]);
			cr_s2  <= CAW'(cr[IDX_W-2:0]);
			dt_s2  <= OVL_W'(1 << FRAC_BITS) - OVL_W'(top_s1[FRAC_BITS-1:0]);
			dl_s2  <= OVL_W'(1 << FRAC_BITS) - OVL_W'(left_s1[FRAC_BITS-1:0]);
			db_s2  <= OVL_W'(bot_s1[FRAC_BITS-1:0]);
			dr_s2  <= OVL_W'(right_s1[FRAC_BITS-1:0]);
		end
	end

	// ---- stage 3: corner bits, overlap compares
	always_comb begin
		cor_c.tl = ok_s2.tl && rd_top_s2[cl_s2];
		cor_c.tr = ok_s2.tr && rd_top_s2[cr_s2];
		cor_c.bl = ok_s2.bl && rd_bot_s2[cl_s2];
		cor_c.br = ok_s2.br && rd_bot_s2[cr_s2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en3) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			bnd_s3    <= bnd_s2;
			cor_s3    <= cor_c;
			t_lt_l_s3 <= dt_s2 < dl_s2;
			t_lt_r_s3 <= dt_s2 < dr_s2;
			b_lt_l_s3 <= db_s2 < dl_s2;
			b_lt_r_s3 <= db_s2 < dr_s2;
		end
	end

	// ---- stage 4: pattern priority
	always_comb begin
		side_c = '0;
		if (cor_s3.tl && cor_s3.tr && cor_s3.bl && cor_s3.br) begin
			side_c = '1;
		end else if (cor_s3.tl && cor_s3.bl && cor_s3.tr) begin
			side_c.left = 1'b1;
			side_c.top  = 1'b1;
		end else if (cor_s3.tl && cor_s3.bl && cor_s3.br) begin
			side_c.left   = 1'b1;
			side_c.bottom = 1'b1;
		end else if (cor_s3.tr && cor_s3.br && cor_s3.tl) begin
			side_c.right = 1'b1;
			side_c.top   = 1'b1;
		end else if (cor_s3.tr && cor_s3.br && cor_s3.bl) begin
			side_c.right  = 1'b1;
			side_c.bottom = 1'b1;
		end else if (cor_s3.tl && cor_s3.tr) begin
			side_c.top = 1'b1;
		end else if (cor_s3.bl && cor_s3.br) begin
			side_c.bottom = 1'b1;
		end else if (cor_s3.tl && cor_s3.bl) begin
			side_c.left = 1'b1;
		end else if (cor_s3.tr && cor_s3.br) begin
			side_c.right = 1'b1;
		end else if ((cor_s3.tr && cor_s3.bl) || (cor_s3.tl && cor_s3.br)) begin
			side_c = '0; // diagonal pair
		end else if (cor_s3.tl) begin
			if (t_lt_l_s3) side_c.top = 1'b1;
			else side_c.left = 1'b1;
		end else if (cor_s3.tr) begin
			if (t_lt_r_s3) side_c.top = 1'b1;
			else side_c.right = 1'b1;
		end else if (cor_s3.bl) begin
			if (b_lt_l_s3) side_c.bottom = 1'b1;
			else side_c.left = 1'b1;
		end else if (cor_s3.br) begin
			if (b_lt_r_s3) side_c.bottom = 1'b1;
			else side_c.right = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en4) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en4) res_s4 <= side_c | bnd_s3;
	end

	assign out_valid  = v_s4;
	assign hit_top    = res_s4.top;
	assign hit_bottom = res_s4.bottom;
	assign hit_left   = res_s4.left;
	assign hit_right  = res_s4.right;

`ifndef SYNTHESIS
	a_clr_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_ready)
		else $error("item taken during clearing pass");

	a_clr_length: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> ($past(clr_row_q) == RAW'(MAP_ROWS - 1)))
		else $error("clearing pass ended early");

	a_full_corners: assert property (@(posedge clk) disable iff (!arst_n)
		(en4 && v_s3 && (&cor_s3)) |=> (hit_top && hit_bottom && hit_left && hit_right))
		else $error("four solid corners did not block all sides");

	a_no_hit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(en4 && v_s3 && !(|cor_s3) && !(|bnd_s3))
		|=> (out_valid && !hit_top && !hit_bottom && !hit_left && !hit_right))
		else $error("flag raised with no corner and no bound hit");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en3) |=> v_s2)
		else $error("stalled stage 2 item lost");
`endif

endmodule
